// ===== rtl/acull_pkg.sv =====
// Shared types and constants for the clip-space box culling block.
// No dependencies; imported by every module of the block.
package acull_pkg;

  // culling plane codes as reported on the result
  typedef enum logic [2:0] {
    PLANE_NONE   = 3'd0,
    PLANE_LEFT   = 3'd1,
    PLANE_RIGHT  = 3'd2,
    PLANE_BOTTOM = 3'd3,
    PLANE_TOP    = 3'd4,
    PLANE_NEAR   = 3'd5,
    PLANE_FAR    = 3'd6
  } plane_t;

  // item kinds
  localparam logic ACT_ROW_LOAD = 1'b0;
  localparam logic ACT_BOX      = 1'b1;

  localparam int NUM_ROWS    = 4;
  localparam int NUM_COLS    = 4;
  localparam int NUM_AXES    = 3;
  localparam int NUM_CORNERS = 8;
  localparam int NUM_PLANES  = 6;
  localparam int NUM_PARTS   = 4;

endpackage

// ===== rtl/aabb_clip_space_frustum_cull_top.sv =====
// Top level of the clip-space box culling block.
// Depends on acull_pkg, acull_xform, acull_corner and acull_plane.
//
// Box items are transformed by the stored 4x4 matrix and tested against the
// six clip planes in a five-stage pipeline: entry products, center sum,
// x/y corner terms, z corner terms, plane test. One item is taken every
// cycle unless a stall at the output has backed up to the input. The 24
// multipliers of the first stage run in parallel. Row loads write the
// matrix at acceptance and produce no result; they apply to every box
// accepted after them. Stalls at the output back up stage by stage, and
// empty stages fill while the output waits.
module aabb_clip_space_frustum_cull_top
  import acull_pkg::*;
#(
  parameter int VALUE_WIDTH   = 32,
  parameter int FRACTION_BITS = 16
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic                   action,
  input  logic [1:0]             row_select,
  input  logic [VALUE_WIDTH-1:0] entry_col0,
  input  logic [VALUE_WIDTH-1:0] entry_col1,
  input  logic [VALUE_WIDTH-1:0] entry_col2,
  input  logic [VALUE_WIDTH-1:0] entry_col3,
  input  logic [VALUE_WIDTH-1:0] center_x,
  input  logic [VALUE_WIDTH-1:0] center_y,
  input  logic [VALUE_WIDTH-1:0] center_z,
  input  logic [VALUE_WIDTH-1:0] half_x,
  input  logic [VALUE_WIDTH-1:0] half_y,
  input  logic [VALUE_WIDTH-1:0] half_z,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic                   visible,
  output logic [2:0]             culling_plane
);

  localparam int PW = 2 * VALUE_WIDTH;
  localparam int SW = (PW > VALUE_WIDTH + FRACTION_BITS) ? PW
                                                         : VALUE_WIDTH + FRACTION_BITS;
  // headroom for four-term sums and the plane difference
  localparam int CW = SW + 5;

  logic [NUM_COLS-1:0][VALUE_WIDTH-1:0]                  entry;
  logic [NUM_AXES-1:0][VALUE_WIDTH-1:0]                  center, half;
  logic [NUM_ROWS-1:0][CW-1:0]                           base;
  logic [NUM_ROWS-1:0][NUM_AXES-1:0][PW-1:0]             ext;
  logic [NUM_CORNERS-1:0][NUM_ROWS-1:0][CW-1:0]          clip;
  logic xf_valid, xf_ready, cn_valid, cn_ready;

  assign entry  = {entry_col3, entry_col2, entry_col1, entry_col0};
  assign center = {center_z, center_y, center_x};
  assign half   = {half_z, half_y, half_x};

  acull_xform #(
    .VALUE_WIDTH  (VALUE_WIDTH),
    .FRACTION_BITS(FRACTION_BITS),
    .CW           (CW)
  ) u_xform (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .action    (action),
    .row_select(row_select),
    .entry     (entry),
    .center    (center),
    .half      (half),
    .out_valid (xf_valid),
    .out_ready (xf_ready),
    .base      (base),
    .ext       (ext)
  );

  acull_corner #(
    .VALUE_WIDTH(VALUE_WIDTH),
    .CW         (CW)
  ) u_corner (
    .clk      (clk),
    .rst      (rst),
    .in_valid (xf_valid),
    .in_ready (xf_ready),
    .base     (base),
    .ext      (ext),
    .out_valid(cn_valid),
    .out_ready(cn_ready),
    .clip     (clip)
  );

  acull_plane #(
    .CW(CW)
  ) u_plane (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (cn_valid),
    .in_ready     (cn_ready),
    .clip         (clip),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .visible      (visible),
    .culling_plane(culling_plane)
  );

endmodule

// ===== rtl/acull_xform.sv =====
// Matrix store plus the two multiply/sum stages of the cull pipeline.
// Depends on acull_pkg.
module acull_xform
  import acull_pkg::*;
#(
  parameter int VALUE_WIDTH   = 32,
  parameter int FRACTION_BITS = 16,
  parameter int CW            = 72
) (
  input  logic                                             clk,
  input  logic                                             rst,
  input  logic                                             in_valid,
  output logic                                             in_ready,
  input  logic                                             action,
  input  logic [1:0]                                       row_select,
  input  logic [NUM_COLS-1:0][VALUE_WIDTH-1:0]             entry,
  input  logic [NUM_AXES-1:0][VALUE_WIDTH-1:0]             center,
  input  logic [NUM_AXES-1:0][VALUE_WIDTH-1:0]             half,
  output logic                                             out_valid,
  input  logic                                             out_ready,
  output logic [NUM_ROWS-1:0][CW-1:0]                      base,
  output logic [NUM_ROWS-1:0][NUM_AXES-1:0][2*VALUE_WIDTH-1:0] ext
);

  localparam int PW = 2 * VALUE_WIDTH;

  logic signed [VALUE_WIDTH-1:0] mat [NUM_ROWS][NUM_COLS];
  logic signed [PW-1:0]          pc  [NUM_ROWS][NUM_AXES];
  logic signed [PW-1:0]          ph  [NUM_ROWS][NUM_AXES];
  logic signed [VALUE_WIDTH-1:0] mw  [NUM_ROWS];
  logic signed [CW-1:0]          base_r [NUM_ROWS];
  logic signed [PW-1:0]          ext_r  [NUM_ROWS][NUM_AXES];
  logic v1, v2, en1, en2, take;

  // stage enables: a stage moves when empty or when the next one moves
  assign en2       = !v2 || out_ready;
  assign en1       = !v1 || en2;
  assign in_ready  = en1;
  assign take      = in_valid && en1;
  assign out_valid = v2;

  // matrix store, written by row loads at acceptance
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int r = 0; r < NUM_ROWS; r++) begin
        for (int c = 0; c < NUM_COLS; c++) begin
          mat[r][c] <= '0;
        end
      end
    end else if (take && action == ACT_ROW_LOAD) begin
      for (int c = 0; c < NUM_COLS; c++) begin
        mat[row_select][c] <= entry[c];
      end
    end
  end

  // valid bits; row loads leave the pipeline here
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      if (en1) v1 <= take && (action == ACT_BOX);
      if (en2) v2 <= v1;
    end
  end

  // stage 1: matrix times center and matrix times half-width, per entry
  always_ff @(posedge clk) begin
    if (en1) begin
      for (int r = 0; r < NUM_ROWS; r++) begin
        for (int a = 0; a < NUM_AXES; a++) begin
          pc[r][a] <= mat[r][a] * $signed(center[a]);
          ph[r][a] <= mat[r][a] * $signed(half[a]);
        end
        mw[r] <= mat[r][NUM_COLS-1];
      end
    end
  end

  // stage 2: clip coordinate of the center (w column times 1.0)
  always_ff @(posedge clk) begin
    if (en2) begin
      for (int r = 0; r < NUM_ROWS; r++) begin
        base_r[r] <= CW'(pc[r][0]) + CW'(pc[r][1]) + CW'(pc[r][2])
                   + (CW'(mw[r]) <<< FRACTION_BITS);
        for (int a = 0; a < NUM_AXES; a++) begin
          ext_r[r][a] <= ph[r][a];
        end
      end
    end
  end

  always_comb begin
    for (int r = 0; r < NUM_ROWS; r++) begin
      base[r] = base_r[r];
      for (int a = 0; a < NUM_AXES; a++) begin
        ext[r][a] = ext_r[r][a];
      end
    end
  end

endmodule

// ===== rtl/acull_corner.sv =====
// Corner expansion stages: center clip value plus or minus the per-axis terms.
// Depends on acull_pkg.
module acull_corner
  import acull_pkg::*;
#(
  parameter int VALUE_WIDTH = 32,
  parameter int CW          = 72
) (
  input  logic                                                 clk,
  input  logic                                                 rst,
  input  logic                                                 in_valid,
  output logic                                                 in_ready,
  input  logic [NUM_ROWS-1:0][CW-1:0]                          base,
  input  logic [NUM_ROWS-1:0][NUM_AXES-1:0][2*VALUE_WIDTH-1:0] ext,
  output logic                                                 out_valid,
  input  logic                                                 out_ready,
  output logic [NUM_CORNERS-1:0][NUM_ROWS-1:0][CW-1:0]         clip
);

  logic signed [CW-1:0] part   [NUM_ROWS][NUM_PARTS];
  logic signed [CW-1:0] ez     [NUM_ROWS];
  logic signed [CW-1:0] clip_r [NUM_CORNERS][NUM_ROWS];
  logic v3, v4, en3, en4;

  assign en4       = !v4 || out_ready;
  assign en3       = !v3 || en4;
  assign in_ready  = en3;
  assign out_valid = v4;

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else begin
      if (en3) v3 <= in_valid;
      if (en4) v4 <= v3;
    end
  end

  // stage 3: x and y signs; part index bit 1 is +x, bit 0 is +y
  always_ff @(posedge clk) begin
    logic signed [CW-1:0] sx, sy;
    if (en3) begin
      for (int r = 0; r < NUM_ROWS; r++) begin
        sx = CW'($signed(ext[r][0]));
        sy = CW'($signed(ext[r][1]));
        part[r][0] <= $signed(base[r]) - sx - sy;
        part[r][1] <= $signed(base[r]) - sx + sy;
        part[r][2] <= $signed(base[r]) + sx - sy;
        part[r][3] <= $signed(base[r]) + sx + sy;
        ez[r]      <= CW'($signed(ext[r][2]));
      end
    end
  end

  // stage 4: z sign; corner bit 2 is +x, bit 1 is +y, bit 0 is +z
  always_ff @(posedge clk) begin
    if (en4) begin
      for (int k = 0; k < NUM_CORNERS; k++) begin
        for (int r = 0; r < NUM_ROWS; r++) begin
          if (k[0]) clip_r[k][r] <= part[r][k[2:1]] + ez[r];
          else      clip_r[k][r] <= part[r][k[2:1]] - ez[r];
        end
      end
    end
  end

  always_comb begin
    for (int k = 0; k < NUM_CORNERS; k++) begin
      for (int r = 0; r < NUM_ROWS; r++) begin
        clip[k][r] = clip_r[k][r];
      end
    end
  end

endmodule

// ===== rtl/acull_plane.sv =====
// Plane test stage: six planes against eight clip-space corners, first cull wins.
// Depends on acull_pkg; drives the block's result register.
module acull_plane
  import acull_pkg::*;
#(
  parameter int CW = 72
) (
  input  logic                                         clk,
  input  logic                                         rst,
  input  logic                                         in_valid,
  output logic                                         in_ready,
  input  logic [NUM_CORNERS-1:0][NUM_ROWS-1:0][CW-1:0] clip,
  output logic                                         out_valid,
  input  logic                                         out_ready,
  output logic                                         visible,
  output logic [2:0]                                   culling_plane
);

  logic [NUM_PLANES-1:0] pass;
  plane_t                plane_next;
  plane_t                plane_r;
  logic                  vis_r;
  logic                  v5, en5;

  assign en5           = !v5 || out_ready;
  assign in_ready      = en5;
  assign out_valid     = v5;
  assign visible       = vis_r;
  assign culling_plane = plane_r;

  // a plane passes if some corner lies strictly inside it
  always_comb begin
    logic signed [CW:0] v, w, d;
    pass = '0;
    for (int p = 0; p < NUM_PLANES; p++) begin
      for (int k = 0; k < NUM_CORNERS; k++) begin
        v = (CW+1)'($signed(clip[k][p/2]));
        w = (CW+1)'($signed(clip[k][NUM_ROWS-1]));
        d = p[0] ? (w - v) : (v + w);
        if (!d[CW] && (d != '0)) pass[p] = 1'b1;
      end
    end
  end

  // lowest failing plane is reported
  always_comb begin
    plane_next = PLANE_NONE;
    for (int p = NUM_PLANES - 1; p >= 0; p--) begin
      if (!pass[p]) plane_next = plane_t'(3'(p + 1));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v5 <= 1'b0;
    end else if (en5) begin
      v5 <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en5) begin
      plane_r <= plane_next;
      vis_r   <= (plane_next == PLANE_NONE);
    end
  end

endmodule

// ===== rtl/acull_checker.sv =====
// Port-level checks for the box culling block, bound to its top level.
// Depends on acull_pkg and aabb_clip_space_frustum_cull_top.
module acull_checker
  import acull_pkg::*;
(
  input logic       clk,
  input logic       rst,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic       visible,
  input logic [2:0] culling_plane
);

  // a waiting result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(visible) && $stable(culling_plane))
    else $error("result changed while stalled");

  // visible flag agrees with the plane code
  a_vis_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (visible == (culling_plane == PLANE_NONE)))
    else $error("visible and culling_plane disagree");

  // the pipeline only pushes back when the output is stalled
  a_ready: assert property (@(posedge clk) disable iff (rst)
    (out_ready || !out_valid) |-> in_ready)
    else $error("input stalled without output backpressure");

  // reset empties the pipeline
  a_reset: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result present right after reset");

endmodule

bind aabb_clip_space_frustum_cull_top acull_checker u_acull_checker (.*);

// ===== test/tb_aabb_clip_space_frustum_cull_top.sv =====
// Self-checking testbench for aabb_clip_space_frustum_cull_top: clip-space box culling.
// Depends on acull_pkg and the RTL of the block; drives random and directed items.
module tb_aabb_clip_space_frustum_cull_top;
  import acull_pkg::*;

  localparam int          FRAC    = 16;
  localparam logic [31:0] ONE_Q   = 32'h0001_0000;
  localparam logic [31:0] HALF_Q  = 32'h0000_8000;
  localparam logic [31:0] ONEH_Q  = 32'h0001_8000;
  localparam logic [31:0] THREE_Q = 32'h0003_0000;
  localparam logic [31:0] MIN_Q   = 32'h8000_0000;
  localparam logic [31:0] MAX_Q   = 32'h7fff_ffff;
  localparam int          RANDOM_ITEMS = 950;

  // Tracks the stored matrix and the cull decisions still owed by the block
  class cull_scoreboard;
    logic [31:0] matrix [16];
    plane_t      expected_planes [$];
    int          errors;
    int          n_boxes, n_loads, n_visible, n_results;
    int          plane_hits [7];

    function new();
      foreach (matrix[i]) matrix[i] = '0;
      foreach (plane_hits[i]) plane_hits[i] = 0;
      errors = 0;
      n_boxes = 0;
      n_loads = 0;
      n_visible = 0;
      n_results = 0;
    endfunction

    function logic signed [127:0] widen(logic [31:0] v);
      return {{96{v[31]}}, v};
    endfunction

    // exact clip-space transform of all eight corners, then planes in order
    function plane_t cull_plane_for_box(logic [2:0][31:0] ctr, logic [2:0][31:0] hw);
      logic signed [127:0] clip [8][4];
      logic signed [127:0] pt [4];
      logic signed [127:0] acc, v, w, d;
      plane_t plane;
      bit any_inside;
      plane = PLANE_NONE;
      for (int k = 0; k < 8; k++) begin
        for (int a = 0; a < 3; a++) begin
          pt[a] = (((k >> (2 - a)) & 1) != 0) ? widen(ctr[a]) + widen(hw[a])
                                              : widen(ctr[a]) - widen(hw[a]);
        end
        pt[3] = 128'sd1 <<< FRAC;
        for (int r = 0; r < 4; r++) begin
          acc = '0;
          for (int c = 0; c < 4; c++) acc += widen(matrix[r*4 + c]) * pt[c];
          clip[k][r] = acc;
        end
      end
      // even planes test -w < v, odd planes test v < w; strict on both sides
      for (int p = 0; p < 6; p++) begin
        if (plane == PLANE_NONE) begin
          any_inside = 1'b0;
          for (int k = 0; k < 8; k++) begin
            v = clip[k][p >> 1];
            w = clip[k][3];
            d = (p % 2 == 1) ? w - v : v + w;
            if (d > 0) any_inside = 1'b1;
          end
          if (!any_inside) plane = plane_t'(p + 1);
        end
      end
      return plane;
    endfunction

    function void note_input(logic act, logic [1:0] row, logic [3:0][31:0] vals,
                             logic [2:0][31:0] ctr, logic [2:0][31:0] hw);
      plane_t plane;
      if (act == ACT_ROW_LOAD) begin
        for (int c = 0; c < 4; c++) matrix[row*4 + c] = vals[c];
        n_loads++;
      end else begin
        plane = cull_plane_for_box(ctr, hw);
        expected_planes.push_back(plane);
        plane_hits[plane]++;
        n_boxes++;
        if (plane == PLANE_NONE) n_visible++;
      end
    endfunction

    function void check_result(logic vis, logic [2:0] plane);
      plane_t exp_plane;
      logic   exp_vis;
      n_results++;
      if (expected_planes.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("result %0d: unexpected, visible=%0d plane=%0d", n_results, vis, plane);
        return;
      end
      exp_plane = expected_planes.pop_front();
      exp_vis   = (exp_plane == PLANE_NONE);
      if (vis !== exp_vis || plane !== exp_plane) begin
        errors++;
        if (errors <= 10)
          $display("result %0d: expected visible=%0d plane=%0d, got visible=%0d plane=%0d",
                   n_results, exp_vis, exp_plane, vis, plane);
      end
    endfunction

    function int pending();
      return expected_planes.size();
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        action = ACT_ROW_LOAD;
  logic [1:0]  row_select = '0;
  logic [31:0] entry_col0 = '0, entry_col1 = '0, entry_col2 = '0, entry_col3 = '0;
  logic [31:0] center_x = '0, center_y = '0, center_z = '0;
  logic [31:0] half_x = '0, half_y = '0, half_z = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic        visible;
  logic [2:0]  culling_plane;

  cull_scoreboard sb = new();
  int burst_left = 0;
  int items_sent = 0;
  int stall_tick = 0;
  int stall_mode = 0;
  int hold_cnt = 0;

  aabb_clip_space_frustum_cull_top u_top (.*);

  always #1 clk = ~clk;

  // accepted items on both sides; results are checked before new items are noted
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) sb.check_result(visible, culling_plane);
    if (!rst && in_valid && in_ready)
      sb.note_input(action, row_select, {entry_col3, entry_col2, entry_col1, entry_col0},
                    {center_z, center_y, center_x}, {half_z, half_y, half_x});
  end

  // receiver back-pressure: pattern switches among four random modes
  always @(posedge clk) begin
    stall_tick++;
    if (stall_tick % 97 == 0) stall_mode = $urandom_range(0, 3);
    case (stall_mode)
      0: out_ready <= 1'b1;
      1: out_ready <= 1'($urandom_range(0, 1));
      2: out_ready <= (stall_tick % 4 == 0);
      default: begin
        if (hold_cnt == 0) begin
          out_ready <= !out_ready;
          hold_cnt = $urandom_range(1, 12);
        end else begin
          hold_cnt--;
        end
      end
    endcase
  end

  function automatic logic [2:0][31:0] vec3(logic [31:0] x, logic [31:0] y, logic [31:0] z);
    return {z, y, x};
  endfunction

  function automatic logic [31:0] small_q(int unsigned span);
    return $urandom_range(0, 2 * span) - span;
  endfunction

  function automatic logic [31:0] pick_extreme();
    case ($urandom_range(0, 3))
      0: return MIN_Q;
      1: return MAX_Q;
      2: return 32'h0;
      default: return 32'hffff_ffff;
    endcase
  endfunction

  // one item; valid stays up across a burst and drops only for a gap
  task automatic send_item(logic act, logic [1:0] row, logic [3:0][31:0] vals,
                           logic [2:0][31:0] ctr, logic [2:0][31:0] hw);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 40);
    end
    burst_left--;
    in_valid   <= 1'b1;
    action     <= act;
    row_select <= row;
    {entry_col3, entry_col2, entry_col1, entry_col0} <= vals;
    {center_z, center_y, center_x} <= ctr;
    {half_z, half_y, half_x} <= hw;
    do @(posedge clk); while (!in_ready);
    items_sent++;
  endtask

  // ignored fields of each item kind carry random bits
  task automatic send_row(logic [1:0] row, logic [3:0][31:0] vals);
    send_item(ACT_ROW_LOAD, row, vals, {$urandom, $urandom, $urandom},
              {$urandom, $urandom, $urandom});
  endtask

  task automatic send_box(logic [2:0][31:0] ctr, logic [2:0][31:0] hw);
    send_item(ACT_BOX, 2'($urandom), {$urandom, $urandom, $urandom, $urandom}, ctr, hw);
  endtask

  initial begin
    int mode, bmode, nbox, base, row;
    logic [3:0][31:0] rowv;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // zero matrix after reset: every box culled on the left plane
    send_box(vec3(0, 0, 0), vec3(0, 0, 0));
    send_box(vec3(MIN_Q, MIN_Q, MIN_Q), vec3(MAX_Q, MAX_Q, MAX_Q));

    // identity matrix
    for (int r = 0; r < 4; r++) begin
      rowv = '0;
      rowv[r] = ONE_Q;
      send_row(2'(r), rowv);
    end
    send_box(vec3(0, 0, 0), vec3(HALF_Q, HALF_Q, HALF_Q));
    send_box(vec3(-THREE_Q, 0, 0), vec3(HALF_Q, HALF_Q, HALF_Q));
    send_box(vec3(THREE_Q, 0, 0), vec3(HALF_Q, HALF_Q, HALF_Q));
    send_box(vec3(0, -THREE_Q, 0), vec3(HALF_Q, HALF_Q, HALF_Q));
    send_box(vec3(0, THREE_Q, 0), vec3(HALF_Q, HALF_Q, HALF_Q));
    send_box(vec3(0, 0, -THREE_Q), vec3(HALF_Q, HALF_Q, HALF_Q));
    send_box(vec3(0, 0, THREE_Q), vec3(HALF_Q, HALF_Q, HALF_Q));
    // negative half-widths, and a corner exactly on the left plane
    send_box(vec3(0, 0, 0), vec3(-HALF_Q, -HALF_Q, -HALF_Q));
    send_box(vec3(-ONEH_Q, 0, 0), vec3(-HALF_Q, HALF_Q, HALF_Q));
    send_box(vec3(MAX_Q, MAX_Q, MAX_Q), vec3(MAX_Q, MAX_Q, MAX_Q));
    send_box(vec3(MIN_Q, MIN_Q, MIN_Q), vec3(MIN_Q, MIN_Q, MIN_Q));

    // extreme matrix entries
    send_row(2'd0, {MIN_Q, MIN_Q, MIN_Q, MIN_Q});
    send_row(2'd3, {MAX_Q, MAX_Q, MAX_Q, MAX_Q});
    send_box(vec3(MIN_Q, MIN_Q, MIN_Q), vec3(MIN_Q, MIN_Q, MIN_Q));
    send_box(vec3(MAX_Q, MAX_Q, MAX_Q), vec3(MIN_Q, MIN_Q, MIN_Q));
    send_row(2'd1, {MAX_Q, MAX_Q, MAX_Q, MAX_Q});
    send_row(2'd2, {MIN_Q, MIN_Q, MIN_Q, MIN_Q});
    send_box({$urandom, $urandom, $urandom}, {$urandom, $urandom, $urandom});

    // random phase: new matrix, then a run of boxes against it
    base = items_sent;
    while (items_sent - base < RANDOM_ITEMS) begin
      mode = $urandom_range(0, 9);
      if (mode == 9) begin
        row = $urandom_range(0, 3);
        for (int c = 0; c < 4; c++)
          rowv[c] = $urandom_range(0, 1) ? small_q(2 * 65536) : $urandom;
        send_row(2'(row), rowv);
      end else begin
        for (int r = 0; r < 4; r++) begin
          for (int c = 0; c < 4; c++) begin
            if (mode < 6)
              rowv[c] = (r == c) ? ONE_Q + small_q(16384)
                                 : ($urandom_range(0, 1) ? small_q(8192) : 32'h0);
            else if (mode < 8)
              rowv[c] = small_q(2 * 65536);
            else
              rowv[c] = $urandom;
          end
          send_row(2'(r), rowv);
        end
      end
      nbox = $urandom_range(5, 30);
      for (int b = 0; b < nbox; b++) begin
        bmode = $urandom_range(0, 9);
        if (bmode < 8)
          send_box(vec3(small_q(3 * 65536), small_q(3 * 65536), small_q(3 * 65536)),
                   vec3(small_q(98304), small_q(98304), small_q(98304)));
        else if (bmode == 8)
          send_box({$urandom, $urandom, $urandom}, {$urandom, $urandom, $urandom});
        else
          send_box(vec3(pick_extreme(), pick_extreme(), pick_extreme()),
                   vec3(pick_extreme(), pick_extreme(), pick_extreme()));
      end
    end

    // drain, then give the pipeline time to show any stray result
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("%0d row loads, %0d boxes: %0d visible, culled L/R/B/T/N/F %0d/%0d/%0d/%0d/%0d/%0d",
             sb.n_loads, sb.n_boxes, sb.n_visible, sb.plane_hits[1], sb.plane_hits[2],
             sb.plane_hits[3], sb.plane_hits[4], sb.plane_hits[5], sb.plane_hits[6]);
    $display("%0d results checked, %0d mismatches", sb.n_results, sb.errors);
    if (sb.errors == 0)
      $display("** aabb_clip_space_frustum_cull_top: PASSED **");
    else
      $display("** aabb_clip_space_frustum_cull_top: FAILED **");
    $finish;
  end

  // watchdog
  initial begin
    #400000;
    $display("timeout with %0d results outstanding", sb.pending());
    $display("** aabb_clip_space_frustum_cull_top: FAILED **");
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/acull_pkg.sv
rtl/acull_xform.sv
rtl/acull_corner.sv
rtl/acull_plane.sv
rtl/aabb_clip_space_frustum_cull_top.sv
rtl/acull_checker.sv
test/tb_aabb_clip_space_frustum_cull_top.sv
